### rtl/ppts_pkg.sv
// Shared types, codes and constants for the periodic priority task scheduler.
`default_nettype none
package ppts_pkg;

    localparam int SLOTS    = 16;
    localparam int SLOT_W   = 4;
    localparam int SIG_W    = 32;
    localparam int SIGN_W   = 5;
    localparam int TIME_W   = 64;
    localparam int NOW_W    = 63;
    localparam int PRIO_W   = 8;
    localparam int CMD_W    = 3;

    localparam logic [TIME_W-1:0] TIME_INF      = '1;
    localparam logic [31:0]       DEFAULT_SCALE = 32'd1000000;
    localparam logic [SIGN_W-1:0] DEFAULT_MAXSIG = 5'd31;

    localparam int SIG_READY   = 0;
    localparam int SIG_TIMER   = 1;
    localparam int SIG_WAKEUP  = 2;
    localparam int SIG_SUSPEND = 3;

    localparam logic [CMD_W-1:0] CMD_SCHEDULE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CREATE   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SIGNAL   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PRIO     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PERIODIC = 3'd4;
    localparam logic [CMD_W-1:0] CMD_WAIT     = 3'd5;
    localparam logic [CMD_W-1:0] CMD_BLOCKED  = 3'd6;

    localparam logic REG_MAX_SIGNAL   = 1'b0;
    localparam logic REG_PERIOD_SCALE = 1'b1;

    localparam logic [1:0] PTR_SLOT = 2'd0;
    localparam logic [1:0] PTR_RUN  = 2'd1;
    localparam logic [1:0] PTR_CNT  = 2'd2;
    localparam logic [1:0] PTR_PICK = 2'd3;

    typedef struct packed {
        logic       load;
        logic       exec;
        logic       per_wr;
        logic       cnt_clr;
        logic       cnt_inc;
        logic [1:0] ptr_sel;
        logic       timer_post;
        logic       div_start;
        logic       base_ld;
        logic       resume_wr;
        logic       scan_clr;
        logic       scan_step;
        logic       handle;
        logic       tried_clr;
        logic       out_load;
    } ppts_ctl_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             cnt_last;
        logic             due;
        logic             per_zero;
        logic             div_done;
        logic             ready_after;
        logic             out_free;
    } ppts_stat_t;

endpackage
`default_nettype wire

### rtl/ppts_div.sv
// Bit-serial restoring remainder unit, one quotient bit per cycle.
`default_nettype none
module ppts_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [ppts_pkg::NOW_W-1:0]  dividend,
    input  wire logic [ppts_pkg::TIME_W-1:0] divisor,
    output logic                            done,
    output logic [ppts_pkg::TIME_W-1:0]      rem
);
    import ppts_pkg::*;

    logic              busy_reg, busy_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic [NOW_W-1:0]  q_reg, q_next;
    logic [TIME_W-1:0] rem_reg, rem_next;
    logic [TIME_W:0]   shifted;
    logic [TIME_W:0]   diff;

    assign shifted = {rem_reg, q_reg[NOW_W-1]};
    assign diff    = shifted - {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'(NOW_W - 1);
            q_next    = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, divisor})
                rem_next = diff[TIME_W-1:0];
            else
                rem_next = shifted[TIME_W-1:0];
            q_next = {q_reg[NOW_W-2:0], 1'b0};
            if (cnt_reg == 6'd0)
                busy_next = 1'b0;
            else
                cnt_next = cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
    end

    assign done = !busy_reg;
    assign rem  = rem_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && busy_reg))
        else $error("divider restarted while busy");
endmodule
`default_nettype wire

### rtl/ppts_dpath.sv
// Datapath: task table, input latch, timer update, pick scan and result register.
`default_nettype none
module ppts_dpath (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire ppts_pkg::ppts_ctl_t         ctl,
    output ppts_pkg::ppts_stat_t             stat,
    input  wire logic                        cfg_valid,
    input  wire logic                        cfg_index,
    input  wire logic [31:0]                 cfg_data,
    input  wire logic [ppts_pkg::CMD_W-1:0]  command,
    input  wire logic [ppts_pkg::NOW_W-1:0]  now_time,
    input  wire logic [ppts_pkg::SLOT_W-1:0] task_slot,
    input  wire logic [ppts_pkg::PRIO_W-1:0] priority_value,
    input  wire logic [ppts_pkg::SIGN_W-1:0] signal_number,
    input  wire logic [31:0]                 period_units,
    input  wire logic [ppts_pkg::SIG_W-1:0]  mask_bits,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [ppts_pkg::SLOT_W-1:0]      chosen_slot,
    output logic [ppts_pkg::SIG_W-1:0]       pending_snapshot,
    output logic                             switched,
    output logic                             status
);
    import ppts_pkg::*;

    // configuration
    logic [SIGN_W-1:0] maxsig_reg;
    logic [31:0]       scale_reg;

    // latched request
    logic [CMD_W-1:0]  cmd_reg;
    logic [NOW_W-1:0]  now_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [PRIO_W-1:0] prio_in_reg;
    logic [SIGN_W-1:0] sig_reg;
    logic [31:0]       units_reg;
    logic [SIG_W-1:0]  mask_reg;
    logic [SLOT_W-1:0] before_reg;

    // task table
    logic              valid_reg   [SLOTS];
    logic              valid_next  [SLOTS];
    logic [PRIO_W-1:0] prio_reg    [SLOTS];
    logic [PRIO_W-1:0] prio_next   [SLOTS];
    logic [TIME_W-1:0] period_reg  [SLOTS];
    logic [TIME_W-1:0] period_next [SLOTS];
    logic [TIME_W-1:0] resume_reg  [SLOTS];
    logic [TIME_W-1:0] resume_next [SLOTS];
    logic [SIG_W-1:0]  pending_reg [SLOTS];
    logic [SIG_W-1:0]  pending_next[SLOTS];
    logic [SIG_W-1:0]  blocked_reg [SLOTS];
    logic [SIG_W-1:0]  blocked_next[SLOTS];
    logic              tried_reg   [SLOTS];
    logic              tried_next  [SLOTS];

    logic [SLOT_W-1:0] run_reg, run_next;
    logic [SLOT_W-1:0] cnt_reg, cnt_next;
    logic [SLOT_W-1:0] pick_reg, pick_next;
    logic [PRIO_W-1:0] best_reg, best_next;
    logic              found_reg, found_next;
    logic              stat_reg, stat_next;
    logic [SIG_W-1:0]  snap_reg, snap_next;
    logic [TIME_W-1:0] prod_reg, prod_next;
    logic [NOW_W-1:0]  base_reg, base_next;

    logic              out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0] out_slot_reg, out_slot_next;
    logic [SIG_W-1:0]  out_snap_reg, out_snap_next;
    logic              out_sw_reg, out_sw_next;
    logic              out_st_reg, out_st_next;

    logic [SLOT_W-1:0] ptr;
    logic              rd_valid;
    logic [PRIO_W-1:0] rd_prio;
    logic [TIME_W-1:0] rd_period;
    logic [TIME_W-1:0] rd_resume;
    logic [SIG_W-1:0]  rd_pend;
    logic [SIG_W-1:0]  rd_blk;
    logic              rd_tried;
    logic [SIG_W-1:0]  handled;
    logic              is_sched;
    logic [TIME_W:0]   res_sum;
    logic              div_done;
    logic [TIME_W-1:0] div_rem;
    logic [NOW_W-1:0]  div_dividend;

    always_comb
    begin
        case (ctl.ptr_sel)
            PTR_SLOT: ptr = slot_reg;
            PTR_RUN:  ptr = run_reg;
            PTR_CNT:  ptr = cnt_reg;
            PTR_PICK: ptr = pick_reg;
            default:  ptr = run_reg;
        endcase
    end

    assign rd_valid  = valid_reg[ptr];
    assign rd_prio   = prio_reg[ptr];
    assign rd_period = period_reg[ptr];
    assign rd_resume = resume_reg[ptr];
    assign rd_pend   = pending_reg[ptr];
    assign rd_blk    = blocked_reg[ptr];
    assign rd_tried  = tried_reg[ptr];

    assign is_sched = (cmd_reg == CMD_SCHEDULE) || (cmd_reg == CMD_WAIT);

    // wake or timer makes ready, else suspend clears it; idle task stays ready
    always_comb
    begin
        handled = rd_pend;
        if (rd_pend[SIG_TIMER] || rd_pend[SIG_WAKEUP])
            handled[SIG_READY] = 1'b1;
        else if (rd_pend[SIG_SUSPEND])
            handled[SIG_READY] = 1'b0;
        handled[SIG_TIMER]   = 1'b0;
        handled[SIG_WAKEUP]  = 1'b0;
        handled[SIG_SUSPEND] = 1'b0;
        if (ptr == '0)
            handled[SIG_READY] = 1'b1;
    end

    // now is below 2^63, so now minus the remainder fits the narrow base
    assign div_dividend = now_reg - rd_resume[NOW_W-1:0];
    assign res_sum      = {2'b00, base_reg} + {1'b0, rd_period};

    ppts_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend (div_dividend),
        .divisor  (rd_period),
        .done     (div_done),
        .rem      (div_rem)
    );

    always_comb
    begin
        valid_next   = valid_reg;
        prio_next    = prio_reg;
        period_next  = period_reg;
        resume_next  = resume_reg;
        pending_next = pending_reg;
        blocked_next = blocked_reg;
        tried_next   = tried_reg;
        run_next     = run_reg;
        cnt_next     = cnt_reg;
        pick_next    = pick_reg;
        best_next    = best_reg;
        found_next   = found_reg;
        stat_next    = stat_reg;
        snap_next    = snap_reg;
        prod_next    = prod_reg;
        base_next    = base_reg;

        if (ctl.load)
            stat_next = 1'b0;

        if (ctl.exec)
        begin
            case (cmd_reg)
                CMD_CREATE:
                begin
                    if (slot_reg == '0)
                        stat_next = 1'b1;
                    else
                    begin
                        valid_next[ptr]   = 1'b1;
                        prio_next[ptr]    = prio_in_reg;
                        period_next[ptr]  = '0;
                        resume_next[ptr]  = TIME_INF;
                        blocked_next[ptr] = '0;
                        pending_next[ptr] = mask_reg | SIG_W'(1);
                    end
                end
                CMD_SIGNAL:
                begin
                    if ((sig_reg > maxsig_reg) || !rd_valid)
                        stat_next = 1'b1;
                    else if (sig_reg != '0)
                        pending_next[ptr] = rd_pend | (SIG_W'(1) << sig_reg);
                end
                CMD_PRIO:
                begin
                    if (!rd_valid)
                        stat_next = 1'b1;
                    else
                        prio_next[ptr] = prio_in_reg;
                end
                CMD_BLOCKED:
                begin
                    if (!rd_valid)
                        stat_next = 1'b1;
                    else if (ptr == '0)
                        blocked_next[ptr] = mask_reg & ~SIG_W'(1);
                    else
                        blocked_next[ptr] = mask_reg;
                end
                CMD_PERIODIC:
                    prod_next = 64'(units_reg) * 64'(scale_reg);
                CMD_WAIT:
                begin
                    if (run_reg != '0)
                        pending_next[ptr] = rd_pend & ~SIG_W'(1);
                end
                default: ;
            endcase
        end

        if (ctl.per_wr)
        begin
            period_next[ptr] = prod_reg;
            resume_next[ptr] = '0;
        end

        if (ctl.cnt_clr)
            cnt_next = '0;
        else if (ctl.cnt_inc)
            cnt_next = cnt_reg + SLOT_W'(1);

        if (ctl.tried_clr)
        begin
            for (int i = 0; i < SLOTS; i++)
                tried_next[i] = 1'b0;
        end

        if (ctl.timer_post)
        begin
            pending_next[ptr][SIG_TIMER] = 1'b1;
            if (rd_period == '0)
                resume_next[ptr] = TIME_INF;
        end

        if (ctl.base_ld)
            base_next = now_reg - div_rem[NOW_W-1:0];

        if (ctl.resume_wr)
            resume_next[ptr] = res_sum[TIME_W] ? TIME_INF : res_sum[TIME_W-1:0];

        if (ctl.scan_step)
        begin
            if (rd_valid && !rd_tried && ((rd_pend & ~rd_blk) != '0)
                && (!found_reg || (rd_prio >= best_reg)))
            begin
                pick_next  = cnt_reg;
                best_next  = rd_prio;
                found_next = 1'b1;
            end
        end

        if (ctl.handle)
        begin
            snap_next         = rd_pend;
            run_next          = ptr;
            pending_next[ptr] = handled;
            if (!handled[SIG_READY])
                tried_next[ptr] = 1'b1;
        end

        // after handle so a rescan starts from a clean pick
        if (ctl.scan_clr)
        begin
            pick_next  = '0;
            best_next  = '0;
            found_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_slot_next  = out_slot_reg;
        out_snap_next  = out_snap_reg;
        out_sw_next    = out_sw_reg;
        out_st_next    = out_st_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (ctl.out_load)
        begin
            out_valid_next = 1'b1;
            out_slot_next  = run_reg;
            out_snap_next  = is_sched ? snap_reg : rd_pend;
            out_sw_next    = is_sched && (run_reg != before_reg);
            out_st_next    = stat_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                valid_reg[i]   <= (i == 0);
                prio_reg[i]    <= '0;
                period_reg[i]  <= '0;
                resume_reg[i]  <= TIME_INF;
                pending_reg[i] <= (i == 0) ? SIG_W'(1) : '0;
                blocked_reg[i] <= '0;
                tried_reg[i]   <= 1'b0;
            end
            run_reg       <= '0;
            cnt_reg       <= '0;
            maxsig_reg    <= DEFAULT_MAXSIG;
            scale_reg     <= DEFAULT_SCALE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            prio_reg      <= prio_next;
            period_reg    <= period_next;
            resume_reg    <= resume_next;
            pending_reg   <= pending_next;
            blocked_reg   <= blocked_next;
            tried_reg     <= tried_next;
            run_reg       <= run_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && (cfg_index == REG_MAX_SIGNAL))
                maxsig_reg <= cfg_data[SIGN_W-1:0];
            if (cfg_valid && (cfg_index == REG_PERIOD_SCALE))
                scale_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg     <= command;
            now_reg     <= now_time;
            slot_reg    <= task_slot;
            prio_in_reg <= priority_value;
            sig_reg     <= signal_number;
            units_reg   <= period_units;
            mask_reg    <= mask_bits;
            before_reg  <= run_reg;
        end
        pick_reg     <= pick_next;
        best_reg     <= best_next;
        found_reg    <= found_next;
        stat_reg     <= stat_next;
        snap_reg     <= snap_next;
        prod_reg     <= prod_next;
        base_reg     <= base_next;
        out_slot_reg <= out_slot_next;
        out_snap_reg <= out_snap_next;
        out_sw_reg   <= out_sw_next;
        out_st_reg   <= out_st_next;
    end

    assign stat.cmd         = cmd_reg;
    assign stat.cnt_last    = (cnt_reg == SLOT_W'(SLOTS - 1));
    assign stat.due         = rd_valid && ({1'b0, now_reg} >= rd_resume);
    assign stat.per_zero    = (rd_period == '0);
    assign stat.div_done    = div_done;
    assign stat.ready_after = handled[SIG_READY];
    assign stat.out_free    = !out_valid_reg || out_ready;

    assign out_valid        = out_valid_reg;
    assign chosen_slot      = out_slot_reg;
    assign pending_snapshot = out_snap_reg;
    assign switched         = out_sw_reg;
    assign status           = out_st_reg;

    a_idle_valid: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[0])
        else $error("idle task lost its slot");
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg[0][SIG_READY])
        else $error("idle task lost ready");
    a_run_valid: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[run_reg])
        else $error("running slot is not a created task");
endmodule
`default_nettype wire

### rtl/ppts_ctrl.sv
// Controller state machine sequencing commands, timer pass and pick scans.
`default_nettype none
module ppts_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire ppts_pkg::ppts_stat_t stat,
    output ppts_pkg::ppts_ctl_t       ctl
);
    import ppts_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EXEC  = 4'd1;
    localparam logic [3:0] S_PER   = 4'd2;
    localparam logic [3:0] S_TCHK  = 4'd3;
    localparam logic [3:0] S_TDIV  = 4'd4;
    localparam logic [3:0] S_TBASE = 4'd5;
    localparam logic [3:0] S_TRES  = 4'd6;
    localparam logic [3:0] S_PSCAN = 4'd7;
    localparam logic [3:0] S_PHDL  = 4'd8;
    localparam logic [3:0] S_RESP  = 4'd9;

    logic [3:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                ctl.exec = 1'b1;
                if ((stat.cmd == CMD_PERIODIC) || (stat.cmd == CMD_WAIT))
                    ctl.ptr_sel = PTR_RUN;
                else
                    ctl.ptr_sel = PTR_SLOT;
                if ((stat.cmd == CMD_SCHEDULE) || (stat.cmd == CMD_WAIT))
                begin
                    ctl.cnt_clr   = 1'b1;
                    ctl.tried_clr = 1'b1;
                    state_next    = S_TCHK;
                end
                else if (stat.cmd == CMD_PERIODIC)
                    state_next = S_PER;
                else
                    state_next = S_RESP;
            end
            S_PER:
            begin
                ctl.ptr_sel = PTR_RUN;
                ctl.per_wr  = 1'b1;
                state_next  = S_RESP;
            end
            S_TCHK:
            begin
                ctl.ptr_sel    = PTR_CNT;
                ctl.timer_post = stat.due;
                if (stat.due && !stat.per_zero)
                begin
                    ctl.div_start = 1'b1;
                    state_next    = S_TDIV;
                end
                else if (stat.cnt_last)
                begin
                    ctl.cnt_clr  = 1'b1;
                    ctl.scan_clr = 1'b1;
                    state_next   = S_PSCAN;
                end
                else
                    ctl.cnt_inc = 1'b1;
            end
            S_TDIV:
            begin
                ctl.ptr_sel = PTR_CNT;
                if (stat.div_done)
                    state_next = S_TBASE;
            end
            S_TBASE:
            begin
                ctl.ptr_sel = PTR_CNT;
                ctl.base_ld = 1'b1;
                state_next  = S_TRES;
            end
            S_TRES:
            begin
                ctl.ptr_sel   = PTR_CNT;
                ctl.resume_wr = 1'b1;
                if (stat.cnt_last)
                begin
                    ctl.cnt_clr  = 1'b1;
                    ctl.scan_clr = 1'b1;
                    state_next   = S_PSCAN;
                end
                else
                begin
                    ctl.cnt_inc = 1'b1;
                    state_next  = S_TCHK;
                end
            end
            S_PSCAN:
            begin
                ctl.ptr_sel   = PTR_CNT;
                ctl.scan_step = 1'b1;
                ctl.cnt_inc   = 1'b1;
                if (stat.cnt_last)
                    state_next = S_PHDL;
            end
            S_PHDL:
            begin
                ctl.ptr_sel = PTR_PICK;
                ctl.handle  = 1'b1;
                if (stat.ready_after)
                    state_next = S_RESP;
                else
                begin
                    ctl.cnt_clr  = 1'b1;
                    ctl.scan_clr = 1'b1;
                    state_next   = S_PSCAN;
                end
            end
            S_RESP:
            begin
                ctl.ptr_sel = PTR_RUN;
                if (stat.out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_EXEC))
        else $error("accepted request not executed");
    a_div_only_due: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.div_start |-> (stat.due && !stat.per_zero))
        else $error("divider started for a task that is not due");
endmodule
`default_nettype wire

### rtl/periodic_priority_task_scheduler_unit.sv
// Top level: periodic fixed-priority task scheduler, controller plus datapath.
// Non-scheduling requests: execute (then period write for make periodic), then result load.
// Schedule and wait: a timer pass over all slots (63-step remainder unit per due periodic
// task), then a pick scan; one rescan per picked task left not ready.
// Throughput: one request at a time; the next is accepted once the result is registered.
// Reset (rst_n, async low): idle task only, running slot 0, registers at their defaults.
`default_nettype none
module periodic_priority_task_scheduler_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic                        cfg_index,
    input  wire logic [31:0]                 cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [ppts_pkg::CMD_W-1:0]  command,
    input  wire logic [ppts_pkg::NOW_W-1:0]  now_time,
    input  wire logic [ppts_pkg::SLOT_W-1:0] task_slot,
    input  wire logic [ppts_pkg::PRIO_W-1:0] priority_value,
    input  wire logic [ppts_pkg::SIGN_W-1:0] signal_number,
    input  wire logic [31:0]                 period_units,
    input  wire logic [ppts_pkg::SIG_W-1:0]  mask_bits,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [ppts_pkg::SLOT_W-1:0]      chosen_slot,
    output logic [ppts_pkg::SIG_W-1:0]       pending_snapshot,
    output logic                             switched,
    output logic                             status
);
    import ppts_pkg::*;

    ppts_ctl_t  ctl;
    ppts_stat_t stat;

    assign cfg_ready = 1'b1;

    ppts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    ppts_dpath u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (ctl),
        .stat             (stat),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .command          (command),
        .now_time         (now_time),
        .task_slot        (task_slot),
        .priority_value   (priority_value),
        .signal_number    (signal_number),
        .period_units     (period_units),
        .mask_bits        (mask_bits),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .chosen_slot      (chosen_slot),
        .pending_snapshot (pending_snapshot),
        .switched         (switched),
        .status           (status)
    );
endmodule
`default_nettype wire

### tb/tb_periodic_priority_task_scheduler_unit.sv
// Testbench for the periodic priority task scheduler: random and directed requests, scoreboard.
`timescale 1ns / 100ps
`default_nettype none
module tb_periodic_priority_task_scheduler_unit;
    import ppts_pkg::*;

    localparam logic [CMD_W-1:0] CMD_NOP = 3'd7;
    localparam int IDLE_LIMIT = 60000;
    localparam logic [62:0] NOW_MAX = {63{1'b1}};

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [SIG_W-1:0]  snap;
        logic              sw;
        logic              st;
    } grant_t;

    class sched_scoreboard;
        logic [SIGN_W-1:0] max_sig;
        logic [31:0]       scale;
        logic              used [SLOTS];
        logic [PRIO_W-1:0] prio [SLOTS];
        logic [63:0]       period [SLOTS];
        logic [63:0]       resume [SLOTS];
        logic [31:0]       pend [SLOTS];
        logic [31:0]       blk [SLOTS];
        logic [SLOT_W-1:0] run;
        grant_t            next_grants [$];

        function new();
            max_sig = DEFAULT_MAXSIG;
            scale = DEFAULT_SCALE;
            for (int s = 0; s < SLOTS; s++)
            begin
                used[s] = 0;
                prio[s] = 0;
                period[s] = 0;
                resume[s] = TIME_INF;
                pend[s] = 0;
                blk[s] = 0;
            end
            used[0] = 1;
            pend[0] = 32'h1;
            run = 0;
        endfunction

        function void set_reg(logic idx, logic [31:0] d);
            if (idx == REG_MAX_SIGNAL)
                max_sig = d[SIGN_W-1:0];
            else
                scale = d;
        endfunction

        function void post_timers(logic [63:0] now);
            logic [63:0] base;
            for (int s = 0; s < SLOTS; s++)
            begin
                if (!used[s] || now < resume[s])
                    continue;
                pend[s][SIG_TIMER] = 1'b1;
                if (period[s] == 0)
                begin
                    resume[s] = TIME_INF;
                    continue;
                end
                base = resume[s] + ((now - resume[s]) / period[s]) * period[s];
                resume[s] = (base > TIME_INF - period[s]) ? TIME_INF : base + period[s];
            end
        endfunction

        function logic settle(int s);
            logic [31:0] p;
            p = pend[s];
            if (p[SIG_WAKEUP] || p[SIG_TIMER])
                p[SIG_READY] = 1'b1;
            else if (p[SIG_SUSPEND])
                p[SIG_READY] = 1'b0;
            p[SIG_SUSPEND] = 0;
            p[SIG_WAKEUP] = 0;
            p[SIG_TIMER] = 0;
            if (s == 0)
                p[SIG_READY] = 1'b1;
            pend[s] = p;
            return p[SIG_READY];
        endfunction

        function logic [31:0] dispatch(logic [63:0] now);
            logic tried [SLOTS];
            logic [31:0] snap;
            int pick;
            snap = 0;
            for (int s = 0; s < SLOTS; s++)
                tried[s] = 0;
            post_timers(now);
            for (int it = 0; it <= SLOTS; it++)
            begin
                pick = -1;
                for (int s = 0; s < SLOTS; s++)
                begin
                    if (!used[s] || tried[s] || (pend[s] & ~blk[s]) == 0)
                        continue;
                    if (pick < 0 || prio[s] >= prio[pick])
                        pick = s;
                end
                if (pick < 0)
                    pick = 0;
                snap = pend[pick];
                run = pick[SLOT_W-1:0];
                if (settle(pick))
                    break;
                tried[pick] = 1;
            end
            return snap;
        endfunction

        function void apply_request(logic [CMD_W-1:0] cmd, logic [62:0] now,
                                    logic [SLOT_W-1:0] slot, logic [PRIO_W-1:0] pv,
                                    logic [SIGN_W-1:0] sig, logic [31:0] units,
                                    logic [31:0] mask);
            grant_t g;
            logic [SLOT_W-1:0] prev;
            logic sched, ok;
            prev = run;
            sched = 0;
            g = '0;
            ok = used[slot];
            case (cmd)
                CMD_SCHEDULE, CMD_WAIT:
                begin
                    if (cmd == CMD_WAIT && run != 0)
                        pend[run][SIG_READY] = 1'b0;
                    g.snap = dispatch({1'b0, now});
                    sched = 1;
                end
                CMD_CREATE:
                    if (slot == 0)
                        g.st = 1;
                    else
                    begin
                        used[slot] = 1;
                        prio[slot] = pv;
                        period[slot] = 0;
                        resume[slot] = TIME_INF;
                        blk[slot] = 0;
                        pend[slot] = mask | 32'h1;
                    end
                CMD_SIGNAL:
                    if (sig > max_sig || !ok)
                        g.st = 1;
                    else if (sig != 0)
                        pend[slot][sig] = 1'b1;
                CMD_PRIO:
                    if (!ok)
                        g.st = 1;
                    else
                        prio[slot] = pv;
                CMD_PERIODIC:
                begin
                    period[run] = 64'(units) * 64'(scale);
                    resume[run] = 0;
                end
                CMD_BLOCKED:
                    if (!ok)
                        g.st = 1;
                    else
                        blk[slot] = (slot == 0) ? (mask & ~32'h1) : mask;
                default: ;
            endcase
            if (!sched)
                g.snap = pend[run];
            g.slot = run;
            g.sw = sched && (run != prev);
            next_grants.push_back(g);
        endfunction

        function logic check(grant_t got, output string msg);
            grant_t e;
            msg = "";
            if (next_grants.size() == 0)
            begin
                msg = "result with nothing expected";
                return 1;
            end
            e = next_grants.pop_front();
            if (got.slot != e.slot)
                msg = {msg, $sformatf(" chosen_slot %0d/%0d", got.slot, e.slot)};
            if (got.snap != e.snap)
                msg = {msg, $sformatf(" pending_snapshot %h/%h", got.snap, e.snap)};
            if (got.sw != e.sw)
                msg = {msg, $sformatf(" switched %0b/%0b", got.sw, e.sw)};
            if (got.st != e.st)
                msg = {msg, $sformatf(" status %0b/%0b", got.st, e.st)};
            return msg != "";
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = 1'b0;
    logic [31:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [CMD_W-1:0] command = '0;
    logic [NOW_W-1:0] now_time = '0;
    logic [SLOT_W-1:0] task_slot = '0;
    logic [PRIO_W-1:0] priority_value = '0;
    logic [SIGN_W-1:0] signal_number = '0;
    logic [31:0] period_units = '0;
    logic [SIG_W-1:0] mask_bits = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [SLOT_W-1:0] chosen_slot;
    logic [SIG_W-1:0] pending_snapshot;
    logic switched;
    logic status;

    sched_scoreboard sb = new();
    int errors = 0;
    int idle_cycles = 0;
    bit calm = 0;
    logic [62:0] tnow = '0;
    logic [31:0] cur_scale = DEFAULT_SCALE;

    periodic_priority_task_scheduler_unit dut (.*);

    always #2 clk = ~clk;

    task automatic report(string msg);
        $display("mismatch at %0t:%s", $realtime, msg);
        errors++;
    endtask

    function automatic int gap_len();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(30, 150);
    endfunction

    task automatic cfg_write(logic idx, logic [31:0] d);
        logic ok;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do
        begin
            @(negedge clk) ok = cfg_ready;
            @(posedge clk);
        end
        while (!ok);
        cfg_valid <= 1'b0;
        sb.set_reg(idx, d);
        if (idx == REG_PERIOD_SCALE)
            cur_scale = d;
        @(posedge clk);
    endtask

    task automatic send(logic [CMD_W-1:0] cmd, logic [62:0] now, logic [SLOT_W-1:0] slot,
                        logic [PRIO_W-1:0] pv, logic [SIGN_W-1:0] sig,
                        logic [31:0] units, logic [31:0] mask);
        int g;
        logic ok;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        now_time <= now;
        task_slot <= slot;
        priority_value <= pv;
        signal_number <= sig;
        period_units <= units;
        mask_bits <= mask;
        do
        begin
            @(negedge clk) ok = in_ready;
            @(posedge clk);
        end
        while (!ok);
        sb.apply_request(cmd, now, slot, pv, sig, units, mask);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.next_grants.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic random_request();
        int r;
        logic [CMD_W-1:0] cmd;
        logic [SLOT_W-1:0] slot;
        logic [SIGN_W-1:0] sig;
        logic [31:0] units, mask;
        logic [62:0] now;
        r = $urandom_range(0, 99);
        if (r < 25) cmd = CMD_SCHEDULE;
        else if (r < 38) cmd = CMD_CREATE;
        else if (r < 58) cmd = CMD_SIGNAL;
        else if (r < 66) cmd = CMD_PRIO;
        else if (r < 76) cmd = CMD_PERIODIC;
        else if (r < 88) cmd = CMD_WAIT;
        else if (r < 98) cmd = CMD_BLOCKED;
        else cmd = CMD_NOP;
        slot = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(1, 7)) : 4'($urandom);
        sig = ($urandom_range(0, 9) < 6) ? 5'($urandom_range(0, 4)) : 5'($urandom);
        units = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 5) : $urandom;
        r = $urandom_range(0, 9);
        if (cmd == CMD_BLOCKED)
            mask = (r < 5) ? 32'h0 : (r < 8) ? ($urandom & 32'hF) : $urandom;
        else
            mask = (r < 7) ? ($urandom & 32'h1F) : $urandom;
        tnow = tnow + 63'($urandom_range(0, 4)) * 63'(cur_scale >> 1) + 63'($urandom_range(0, 20));
        now = ($urandom_range(0, 19) == 0) ? {31'($urandom), $urandom} : tnow;
        send(cmd, now, slot, 8'($urandom), sig, units, mask);
    endtask

    // response side: sample mid-cycle, act on the following edge
    initial
    begin
        grant_t got;
        string msg;
        logic hs;
        int stall;
        stall = 0;
        forever
        begin
            @(negedge clk);
            hs = out_valid && out_ready;
            got = '{chosen_slot, pending_snapshot, switched, status};
            @(posedge clk);
            if (hs && sb.check(got, msg))
                report(msg);
            if (stall > 0)
            begin
                stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                stall = gap_len();
            end
        end
    end

    always @(negedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[periodic_priority_task_scheduler_unit] ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: bad slots, bad signals, idle protection, extremes of time
        send(CMD_SCHEDULE, 0, 0, 0, 0, 0, 0);
        send(CMD_CREATE, 0, 0, 8'd5, 0, 0, 32'hFFFF_FFFF);
        send(CMD_CREATE, 0, 1, 8'd10, 0, 0, 0);
        send(CMD_CREATE, 0, 15, 8'd255, 0, 0, 32'hFFFF_FFFF);
        send(CMD_CREATE, 0, 2, 8'd10, 0, 0, 0);
        send(CMD_SIGNAL, 0, 5, 0, 5'd2, 0, 0);
        send(CMD_SIGNAL, 0, 1, 0, 5'd31, 0, 0);
        send(CMD_SIGNAL, 0, 1, 0, 5'd0, 0, 0);
        send(CMD_PRIO, 0, 15, 8'd0, 0, 0, 0);
        send(CMD_PRIO, 0, 7, 8'd9, 0, 0, 0);
        send(CMD_BLOCKED, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
        send(CMD_BLOCKED, 0, 15, 0, 0, 0, 32'hFFFF_FFFF);
        send(CMD_SCHEDULE, 100, 0, 0, 0, 0, 0);
        send(CMD_SIGNAL, 0, 2, 0, 5'(SIG_SUSPEND), 0, 0);
        send(CMD_SCHEDULE, 200, 0, 0, 0, 0, 0);
        send(CMD_PERIODIC, 0, 0, 0, 0, 32'd1, 0);
        send(CMD_WAIT, 1000, 0, 0, 0, 0, 0);
        send(CMD_SIGNAL, 0, 1, 0, 5'(SIG_WAKEUP), 0, 0);
        send(CMD_SCHEDULE, 3000000, 0, 0, 0, 0, 0);
        send(CMD_NOP, NOW_MAX, 15, 8'hFF, 5'h1F, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(CMD_SCHEDULE, NOW_MAX, 0, 0, 0, 0, 0);
        send(CMD_BLOCKED, 0, 15, 0, 0, 0, 0);
        send(CMD_PERIODIC, 0, 0, 0, 0, 32'hFFFF_FFFF, 0);
        send(CMD_WAIT, NOW_MAX, 0, 0, 0, 0, 0);
        send(CMD_SCHEDULE, 0, 0, 0, 0, 0, 0);

        for (int ph = 0; ph < 4; ph++)
        begin
            drain();
            case (ph)
                1:
                begin
                    cfg_write(REG_MAX_SIGNAL, 32'd3);
                    cfg_write(REG_PERIOD_SCALE, 32'd1);
                end
                2:
                begin
                    calm = 1;
                    cfg_write(REG_MAX_SIGNAL, 32'd0);
                    cfg_write(REG_PERIOD_SCALE, 32'hFFFF_FFFF);
                end
                3:
                begin
                    calm = 0;
                    cfg_write(REG_MAX_SIGNAL, 32'd31);
                    cfg_write(REG_PERIOD_SCALE, $urandom_range(1, 1000));
                end
                default: ;
            endcase
            tnow = '0;
            for (int i = 0; i < 270; i++)
            begin
                random_request();
                if (ph == 0 && i == 130)
                    drain();
            end
        end

        drain();
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("[periodic_priority_task_scheduler_unit] OK");
        else
            $display("[periodic_priority_task_scheduler_unit] ERROR");
        $finish;
    end
endmodule
`default_nettype wire
